>>> rtl/mmcc_pkg.sv
// mmcc_pkg: shared types, register map and constants of the multimode current controller
// used by mmcc_cfg and multimode_current_controller; depends on nothing
`default_nettype none

package mmcc_pkg;

    // field widths
    localparam int ADC_W      = 16;
    localparam int CUR_W      = 11;
    localparam int ERR_W      = CUR_W + 1;
    localparam int DUTY_W     = 15;
    localparam int MODE_W     = 3;
    localparam int GAIN_W     = 32;
    localparam int PGAIN_W    = 16;

    // apb port
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_AW     = REG_IDX_W + 2;

    // default parameter values
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADC_BITS_DEF  = 16;

    // scaling constants
    localparam int SCALE_MA   = 1500;
    localparam int PROP_SHIFT = 8;

    // controller modes
    localparam logic [MODE_W-1:0] MODE_OPEN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BANG = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INCR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PROP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PID  = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KP         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KI         = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_KD         = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_LIMIT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_STEP  = 3'd7;

    // register reset values
    localparam logic [MODE_W-1:0]  RST_MODE       = MODE_OPEN;
    localparam logic               RST_ENABLE     = 1'b1;
    localparam logic [PGAIN_W-1:0] RST_PROP_GAIN  = 16'd256;
    localparam logic [GAIN_W-1:0]  RST_KP         = 32'd65536;
    localparam logic [GAIN_W-1:0]  RST_KI         = 32'd0;
    localparam logic [GAIN_W-1:0]  RST_KD         = 32'd0;
    localparam logic [DUTY_W-1:0]  RST_DUTY_LIMIT = 15'd1000;
    localparam logic [DUTY_W-1:0]  RST_DUTY_STEP  = 15'd1;

    // state reset values
    localparam logic [DUTY_W-1:0]  RST_DUTY       = 15'd5;

    // configuration seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic                      enable;
        logic [PGAIN_W-1:0]        prop_gain;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic [DUTY_W-1:0]         duty_limit;
        logic [DUTY_W-1:0]         duty_step;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/mmcc_cfg.sv
// mmcc_cfg: apb register file holding the controller configuration
// depends on mmcc_pkg
`default_nettype none

module mmcc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmcc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mmcc_pkg::APB_DW-1:0]   pwdata,
    output logic      [mmcc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output mmcc_pkg::t_cfg                     o_cfg
);

    mmcc_pkg::t_cfg                   r_cfg;
    logic                             w_wr;
    logic [mmcc_pkg::REG_IDX_W-1:0]   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[mmcc_pkg::APB_AW-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= mmcc_pkg::RST_MODE;
            r_cfg.enable     <= mmcc_pkg::RST_ENABLE;
            r_cfg.prop_gain  <= mmcc_pkg::RST_PROP_GAIN;
            r_cfg.kp         <= mmcc_pkg::RST_KP;
            r_cfg.ki         <= mmcc_pkg::RST_KI;
            r_cfg.kd         <= mmcc_pkg::RST_KD;
            r_cfg.duty_limit <= mmcc_pkg::RST_DUTY_LIMIT;
            r_cfg.duty_step  <= mmcc_pkg::RST_DUTY_STEP;
        end else if (w_wr) begin
            unique case (w_idx)
                mmcc_pkg::REG_MODE:       r_cfg.mode       <= pwdata[mmcc_pkg::MODE_W-1:0];
                mmcc_pkg::REG_ENABLE:     r_cfg.enable     <= pwdata[0];
                mmcc_pkg::REG_PROP_GAIN:  r_cfg.prop_gain  <= pwdata[mmcc_pkg::PGAIN_W-1:0];
                mmcc_pkg::REG_KP:         r_cfg.kp         <= pwdata[mmcc_pkg::GAIN_W-1:0];
                mmcc_pkg::REG_KI:         r_cfg.ki         <= pwdata[mmcc_pkg::GAIN_W-1:0];
                mmcc_pkg::REG_KD:         r_cfg.kd         <= pwdata[mmcc_pkg::GAIN_W-1:0];
                mmcc_pkg::REG_DUTY_LIMIT: r_cfg.duty_limit <= pwdata[mmcc_pkg::DUTY_W-1:0];
                mmcc_pkg::REG_DUTY_STEP:  r_cfg.duty_step  <= pwdata[mmcc_pkg::DUTY_W-1:0];
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            mmcc_pkg::REG_MODE:       prdata = mmcc_pkg::APB_DW'(r_cfg.mode);
            mmcc_pkg::REG_ENABLE:     prdata = mmcc_pkg::APB_DW'(r_cfg.enable);
            mmcc_pkg::REG_PROP_GAIN:  prdata = mmcc_pkg::APB_DW'(r_cfg.prop_gain);
            mmcc_pkg::REG_KP:         prdata = mmcc_pkg::APB_DW'(unsigned'(r_cfg.kp));
            mmcc_pkg::REG_KI:         prdata = mmcc_pkg::APB_DW'(unsigned'(r_cfg.ki));
            mmcc_pkg::REG_KD:         prdata = mmcc_pkg::APB_DW'(unsigned'(r_cfg.kd));
            mmcc_pkg::REG_DUTY_LIMIT: prdata = mmcc_pkg::APB_DW'(r_cfg.duty_limit);
            mmcc_pkg::REG_DUTY_STEP:  prdata = mmcc_pkg::APB_DW'(r_cfg.duty_step);
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/multimode_current_controller.sv
// multimode_current_controller: top level, sample scaling and five-mode duty update pipeline
// depends on mmcc_pkg and mmcc_cfg
`default_nettype none

// Takes one word per cycle while o_in_ready is high: a raw current-sense sample and the target
// current. The sample is scaled to milliamps as (sample*1500)>>ADC_BITS and the PWM duty is
// updated in the mode held in the mode register (open loop, bang-bang, incremental,
// proportional, PID with an integrator clamped to +/- duty_limit). Throughput is one word per
// clock while the result channel is not stalled; each word passes through the five registers
// of the path: input register, error and integrator stage, multiplier stage, delta stage, and
// the duty register that also serves as output register. The integrator and the duty each
// close their feedback loop inside one stage. Configuration must be written over the APB port
// only while no word is in flight, which the block does not enforce; pready is always high.
module multimode_current_controller #(
    parameter int FRAC_BITS = mmcc_pkg::FRAC_BITS_DEF,
    parameter int ADC_BITS  = mmcc_pkg::ADC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mmcc_pkg::ADC_W-1:0]    i_adc_sample,
    input  wire logic [mmcc_pkg::CUR_W-1:0]    i_set_current,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [mmcc_pkg::DUTY_W-1:0]   o_duty,
    output logic      [mmcc_pkg::CUR_W-1:0]    o_measured_current,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mmcc_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mmcc_pkg::APB_DW-1:0]   pwdata,
    output logic      [mmcc_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    localparam int CUR_W   = mmcc_pkg::CUR_W;
    localparam int ERR_W   = mmcc_pkg::ERR_W;
    localparam int DUTY_W  = mmcc_pkg::DUTY_W;
    localparam int GAIN_W  = mmcc_pkg::GAIN_W;
    localparam int SC_W    = ADC_BITS + CUR_W;
    localparam int INT_W   = FRAC_BITS + DUTY_W + 1;
    localparam int IACC_W  = INT_W + 1;
    localparam int EXT_W   = IACC_W - ERR_W - FRAC_BITS;
    localparam int P_W     = GAIN_W + ERR_W;
    localparam int I_W     = GAIN_W + INT_W;
    localparam int ISH_W   = I_W - FRAC_BITS;
    localparam int SUM_W   = ISH_W + 1;
    localparam int DELTA_W = SUM_W - FRAC_BITS;
    localparam int ACC_W   = DELTA_W + 1;
    localparam int PR_W    = mmcc_pkg::PGAIN_W + 1 + ERR_W;
    localparam int PRQ_W   = PR_W - mmcc_pkg::PROP_SHIFT;
    localparam logic [PR_W-1:0] PR_RND = PR_W'((1 << mmcc_pkg::PROP_SHIFT) - 1);

    mmcc_pkg::t_cfg cfg;

    mmcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage valids and moves
    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic w_mv0, w_mv1, w_mv2, w_mv3, w_mv4;
    logic w_free1, w_free2, w_free3, w_free4;

    assign w_free4    = !r_vo || i_out_ready;
    assign w_mv4      = r_v3 && w_free4;
    assign w_free3    = !r_v3 || w_mv4;
    assign w_mv3      = r_v2 && w_free3;
    assign w_free2    = !r_v2 || w_mv3;
    assign w_mv2      = r_v1 && w_free2;
    assign w_free1    = !r_v1 || w_mv2;
    assign w_mv1      = r_v0 && w_free1;
    assign o_in_ready = !r_v0 || w_mv1;
    assign w_mv0      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v0 <= w_mv0 || (r_v0 && !w_mv1);
            r_v1 <= w_mv1 || (r_v1 && !w_mv2);
            r_v2 <= w_mv2 || (r_v2 && !w_mv3);
            r_v3 <= w_mv3 || (r_v3 && !w_mv4);
            r_vo <= w_mv4 || (r_vo && !i_out_ready);
        end
    end

    // stage 0: scale sample to milliamps
    logic [SC_W-1:0]  w_scaled;
    logic [CUR_W-1:0] r_meas0, r_setc0;

    assign w_scaled = SC_W'(i_adc_sample[ADC_BITS-1:0]) * SC_W'(mmcc_pkg::SCALE_MA);

    always_ff @(posedge i_clk) begin
        if (w_mv0) begin
            r_meas0 <= w_scaled[ADC_BITS +: CUR_W];
            r_setc0 <= i_set_current;
        end
    end

    // stage 1: error, position change, clamped integrator
    logic                     w_pid_on;
    logic signed [ERR_W-1:0]  w_err, w_dpos;
    logic signed [IACC_W-1:0] w_err_fx, w_int_sum, w_lim, w_nlim;
    logic signed [INT_W-1:0]  w_int_next;
    logic signed [INT_W-1:0]  r_integ, r_integ1;
    logic [CUR_W-1:0]         r_last;
    logic signed [ERR_W-1:0]  r_err1, r_dpos1;
    logic [CUR_W-1:0]         r_meas1;

    assign w_pid_on  = cfg.enable && (cfg.mode == mmcc_pkg::MODE_PID);
    assign w_err     = $signed({1'b0, r_setc0}) - $signed({1'b0, r_meas0});
    assign w_dpos    = $signed({1'b0, r_meas0}) - $signed({1'b0, r_last});
    assign w_err_fx  = $signed({{EXT_W{w_err[ERR_W-1]}}, w_err, {FRAC_BITS{1'b0}}});
    assign w_int_sum = $signed({r_integ[INT_W-1], r_integ}) + w_err_fx;
    assign w_lim     = $signed({2'b00, cfg.duty_limit, {FRAC_BITS{1'b0}}});
    assign w_nlim    = -w_lim;

    always_comb begin
        priority if (w_int_sum > w_lim) begin
            w_int_next = w_lim[INT_W-1:0];
        end else if (w_int_sum < w_nlim) begin
            w_int_next = w_nlim[INT_W-1:0];
        end else begin
            w_int_next = w_int_sum[INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (w_mv1 && w_pid_on) begin
            r_integ <= w_int_next;
            r_last  <= r_meas0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv1) begin
            r_err1   <= w_err;
            r_dpos1  <= w_dpos;
            r_integ1 <= w_int_next;
            r_meas1  <= r_meas0;
        end
    end

    // stage 2: gain multipliers
    logic signed [P_W-1:0]   r_p2, r_d2;
    logic signed [I_W-1:0]   r_i2;
    logic signed [PR_W-1:0]  r_pr2;
    logic signed [ERR_W-1:0] r_err2;
    logic [CUR_W-1:0]        r_meas2;

    always_ff @(posedge i_clk) begin
        if (w_mv2) begin
            r_p2    <= P_W'(cfg.kp * r_err1);
            r_i2    <= I_W'(cfg.ki * r_integ1);
            r_d2    <= P_W'(cfg.kd * r_dpos1);
            r_pr2   <= PR_W'($signed({1'b0, cfg.prop_gain}) * r_err1);
            r_err2  <= r_err1;
            r_meas2 <= r_meas1;
        end
    end

    // stage 3: duty change per mode
    logic signed [ISH_W-1:0]   w_i_sh;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [PR_W-1:0]    w_pr_adj;
    logic signed [PRQ_W-1:0]   w_pr_q;
    logic signed [DELTA_W-1:0] w_step, w_delta;
    logic                      w_below;
    logic signed [DELTA_W-1:0] r_delta3;
    logic                      r_bang3, r_below3;
    logic [CUR_W-1:0]          r_meas3;

    assign w_i_sh   = $signed(r_i2[FRAC_BITS +: ISH_W]);
    assign w_sum    = SUM_W'(r_p2) + SUM_W'(w_i_sh) - SUM_W'(r_d2);
    // proportional quotient truncates toward zero
    assign w_pr_adj = r_pr2 + (r_pr2[PR_W-1] ? $signed(PR_RND) : $signed(PR_W'(0)));
    assign w_pr_q   = $signed(w_pr_adj[PR_W-1:mmcc_pkg::PROP_SHIFT]);
    assign w_step   = $signed(DELTA_W'(cfg.duty_step));
    assign w_below  = !r_err2[ERR_W-1] && (r_err2 != '0);

    always_comb begin
        unique case (cfg.mode)
            mmcc_pkg::MODE_INCR: w_delta = w_below ? w_step : -w_step;
            mmcc_pkg::MODE_PROP: w_delta = DELTA_W'(w_pr_q);
            mmcc_pkg::MODE_PID:  w_delta = $signed(w_sum[SUM_W-1:FRAC_BITS]);
            default:             w_delta = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mv3) begin
            r_delta3 <= w_delta;
            r_bang3  <= (cfg.mode == mmcc_pkg::MODE_BANG);
            r_below3 <= w_below;
            r_meas3  <= r_meas2;
        end
    end

    // stage 4: duty accumulate and clamp, result register
    logic signed [ACC_W-1:0] w_acc;
    logic [DUTY_W-1:0]       w_duty_next;
    logic [DUTY_W-1:0]       r_duty;
    logic [CUR_W-1:0]        r_meas_o;

    assign w_acc = $signed(ACC_W'(r_duty)) + ACC_W'(r_delta3);

    always_comb begin
        priority if (r_bang3) begin
            w_duty_next = r_below3 ? cfg.duty_limit : '0;
        end else if (w_acc < $signed(ACC_W'(0))) begin
            w_duty_next = '0;
        end else if (w_acc > $signed(ACC_W'(cfg.duty_limit))) begin
            w_duty_next = cfg.duty_limit;
        end else begin
            w_duty_next = w_acc[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty <= mmcc_pkg::RST_DUTY;
        end else if (w_mv4 && cfg.enable) begin
            r_duty <= w_duty_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv4) begin
            r_meas_o <= r_meas3;
        end
    end

    assign o_out_valid        = r_vo;
    assign o_duty             = r_duty;
    assign o_measured_current = r_meas_o;

    // checks
    a_duty_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && cfg.enable) |-> (r_duty <= cfg.duty_limit))
        else $error("duty above limit while enabled");

    a_bang_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv4 && cfg.enable && r_bang3) |=> (r_duty == '0 || r_duty == cfg.duty_limit))
        else $error("bang-bang duty not at an extreme");

    a_disabled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mv4 && !cfg.enable) |=> $stable(r_duty))
        else $error("duty changed while control disabled");

endmodule

`default_nettype wire
